// File: sv/etc2_pkg.sv
package etc2_pkg;

   localparam int BlockWidth = 64;
   localparam int ChanWidth  = 8;
   localparam int QueueDepthDefault = 2;

   typedef enum logic [2:0] {
      MODE_INDIV,
      MODE_DIFF,
      MODE_T,
      MODE_H,
      MODE_PLANAR
   } mode_type;

   // classified block handed from front to back
   typedef struct packed {
      mode_type               mode;
      logic                   transp;
      logic                   flip;
      logic [2:0][1:0][7:0]   base;     // [chan][half] for indiv/diff/t/h
      logic [2:0]             tsel0;
      logic [2:0]             tsel1;
      logic [6:0]             tdist;
      logic [2:0][7:0]        po;       // planar origin
      logic [2:0][7:0]        ph;
      logic [2:0][7:0]        pv;
      logic [31:0]            idx;      // msb plane then lsb plane
   } job_type;

   function automatic logic [7:0] mod_small(input logic [2:0] t);
      unique case (t)
         3'd0: return 8'd2;
         3'd1: return 8'd5;
         3'd2: return 8'd9;
         3'd3: return 8'd13;
         3'd4: return 8'd18;
         3'd5: return 8'd24;
         3'd6: return 8'd33;
         default: return 8'd47;
      endcase
   endfunction

   function automatic logic [7:0] mod_large(input logic [2:0] t);
      unique case (t)
         3'd0: return 8'd8;
         3'd1: return 8'd17;
         3'd2: return 8'd29;
         3'd3: return 8'd42;
         3'd4: return 8'd60;
         3'd5: return 8'd80;
         3'd6: return 8'd106;
         default: return 8'd183;
      endcase
   endfunction

   function automatic logic [6:0] dist_val(input logic [2:0] t);
      unique case (t)
         3'd0: return 7'd3;
         3'd1: return 7'd6;
         3'd2: return 7'd11;
         3'd3: return 7'd16;
         3'd4: return 7'd23;
         3'd5: return 7'd32;
         3'd6: return 7'd41;
         default: return 7'd64;
      endcase
   endfunction

   function automatic logic [7:0] sat8(input logic signed [11:0] v);
      if (v < 0) return 8'd0;
      if (v > 12'sd255) return 8'd255;
      return v[7:0];
   endfunction

endpackage

// File: sv/etc2_if.sv
interface etc2_block_if;
   logic        valid;
   logic        ready;
   logic [63:0] block;
   modport source (output valid, output block, input ready);
   modport sink (input valid, input block, output ready);
endinterface

interface etc2_texel_if;
   logic       valid;
   logic       ready;
   logic [1:0] texel_x;
   logic [1:0] texel_y;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last;
   modport source (output valid, output texel_x, output texel_y, output red, output green,
                   output blue, output alpha, output last, input ready);
   modport sink (input valid, input texel_x, input texel_y, input red, input green,
                 input blue, input alpha, input last, output ready);
endinterface

interface etc2_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/etc2_front.sv
module etc2_front (
   input  logic             punch_through,
   input  logic [63:0]      block,
   output etc2_pkg::job_type job
);
   import etc2_pkg::*;

   logic [7:0][7:0] bt;
   logic signed [5:0] rs, gs, bs;
   logic dbit, diff;
   logic [3:0] r1, g1, b1, r2, g2, b2;
   logic [3:0] c1r, c1g, c1b, c2r, c2g, c2b;
   logic [4:0] er, eg, eb;
   logic [6:0] ogr, hgr, vgr;
   logic [5:0] orr, obb, hr, hb, vr, vb;

   function automatic logic [7:0] e4(input logic [3:0] v);
      return {v, v};
   endfunction
   function automatic logic [7:0] e5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction
   function automatic logic [7:0] e6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction
   function automatic logic [7:0] e7(input logic [6:0] v);
      return {v, v[6]};
   endfunction

   always_comb begin
      for (int i = 0; i < 8; i++) bt[i] = block[63 - 8*i -: 8];
      dbit = bt[3][1];
      diff = punch_through | dbit;
      rs = $signed({1'b0, bt[0][7:3]}) + $signed({{3{bt[0][2]}}, bt[0][2:0]});
      gs = $signed({1'b0, bt[1][7:3]}) + $signed({{3{bt[1][2]}}, bt[1][2:0]});
      bs = $signed({1'b0, bt[2][7:3]}) + $signed({{3{bt[2][2]}}, bt[2][2:0]});
      er = rs[4:0];
      eg = gs[4:0];
      eb = bs[4:0];
      // t mode colors
      c1r = {bt[0][4:3], bt[0][1:0]};
      c1g = bt[1][7:4];
      c1b = bt[1][3:0];
      c2r = bt[2][7:4];
      c2g = bt[2][3:0];
      c2b = bt[3][7:4];
      // h mode colors
      r1 = bt[0][6:3];
      g1 = {bt[0][2:0], bt[1][4]};
      b1 = {bt[1][3], bt[1][1:0], bt[2][7]};
      r2 = bt[2][6:3];
      g2 = {bt[2][2:0], bt[3][7]};
      b2 = bt[3][6:3];
      // planar
      orr = bt[0][6:1];
      ogr = {bt[0][0], bt[1][6:1]};
      obb = {bt[1][0], bt[2][4:3], bt[2][1:0], bt[3][7]};
      hr  = {bt[3][6:2], bt[3][0]};
      hgr = bt[4][7:1];
      hb  = {bt[4][0], bt[5][7:3]};
      vr  = {bt[5][2:0], bt[6][7:5]};
      vgr = {bt[6][4:0], bt[7][7:6]};
      vb  = bt[7][5:0];

      job = '0;
      job.flip   = bt[3][0];
      job.tsel0  = bt[3][7:5];
      job.tsel1  = bt[3][4:2];
      job.transp = punch_through & ~dbit;
      job.idx    = {bt[4], bt[5], bt[6], bt[7]};
      job.po     = {e6(obb), e7(ogr), e6(orr)};
      job.ph     = {e6(hb), e7(hgr), e6(hr)};
      job.pv     = {e6(vb), e7(vgr), e6(vr)};
      priority if (!diff) begin
         job.mode = MODE_INDIV;
         for (int c = 0; c < 3; c++) begin
            job.base[c][0] = e4(bt[c][7:4]);
            job.base[c][1] = e4(bt[c][3:0]);
         end
      end else if (rs < 0 || rs > 31) begin
         job.mode = MODE_T;
         job.tdist = dist_val({bt[3][3:2], bt[3][0]});
         job.base[0] = {e4(c2r), e4(c1r)};
         job.base[1] = {e4(c2g), e4(c1g)};
         job.base[2] = {e4(c2b), e4(c1b)};
      end else if (gs < 0 || gs > 31) begin
         job.mode = MODE_H;
         job.tdist = dist_val({bt[3][2], bt[3][0], ({r1, g1, b1} >= {r2, g2, b2})});
         job.base[0] = {e4(r2), e4(r1)};
         job.base[1] = {e4(g2), e4(g1)};
         job.base[2] = {e4(b2), e4(b1)};
      end else if (bs < 0 || bs > 31) begin
         job.mode = MODE_PLANAR;
         job.transp = 1'b0;
      end else begin
         job.mode = MODE_DIFF;
         job.base[0] = {e5(er), e5(bt[0][7:3])};
         job.base[1] = {e5(eg), e5(bt[1][7:3])};
         job.base[2] = {e5(eb), e5(bt[2][7:3])};
      end
   end
endmodule

// File: sv/etc2_queue.sv
module etc2_queue #(
   parameter int Depth = etc2_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  etc2_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output etc2_pkg::job_type pop_data,
   output logic              empty
);
   import etc2_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   job_type          mem_ff [Depth];
   logic [PtrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]    cnt_ff, cnt_in;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (cnt_ff == (PtrW+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// File: sv/etc2_back.sv
module etc2_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  etc2_pkg::job_type job,
   output logic              job_pop,
   etc2_texel_if.source      rsp
);
   import etc2_pkg::*;

   logic [3:0]  k_ff, k_in;
   logic        ov_ff, ov_in;
   logic [1:0]  ox_ff, oy_ff;
   logic [7:0]  or_ff, og_ff, ob_ff, oa_ff;
   logic        ol_ff;
   logic        adv;
   logic [1:0]  x, y, ix;
   logic [3:0]  bit_sel;
   logic        s;
   logic [2:0]  ts;
   logic signed [11:0] m;
   logic [2:0][7:0] col;
   logic [7:0]  alpha;

   assign x = k_ff[1:0];
   assign y = k_ff[3:2];
   assign adv = job_valid && (!ov_ff || rsp.ready);
   assign job_pop = adv && (k_ff == 4'd15);

   always_comb begin
      logic signed [11:0] sum;
      logic signed [11:0] dx, dy;
      sum = '0;
      dx  = '0;
      dy  = '0;
      bit_sel = {x, y};
      ix = {job.idx[{1'b1, bit_sel}], job.idx[{1'b0, bit_sel}]};
      s  = job.flip ? y[1] : x[1];
      ts = s ? job.tsel1 : job.tsel0;
      alpha = 8'd255;
      m = '0;
      col = '0;
      unique case (job.mode)
         MODE_INDIV, MODE_DIFF: begin
            unique case (ix)
               2'd0: m = job.transp ? 12'sd0 : $signed({4'd0, mod_small(ts)});
               2'd1: m = $signed({4'd0, mod_large(ts)});
               2'd2: m = -$signed({4'd0, mod_small(ts)});
               default: m = -$signed({4'd0, mod_large(ts)});
            endcase
            for (int c = 0; c < 3; c++)
               col[c] = sat8($signed({4'd0, job.base[c][s]}) + m);
         end
         MODE_T: begin
            for (int c = 0; c < 3; c++) begin
               unique case (ix)
                  2'd0: sum = $signed({4'd0, job.base[c][0]});
                  2'd1: sum = $signed({4'd0, job.base[c][1]}) + $signed({5'd0, job.tdist});
                  2'd2: sum = $signed({4'd0, job.base[c][1]});
                  default: sum = $signed({4'd0, job.base[c][1]}) - $signed({5'd0, job.tdist});
               endcase
               col[c] = sat8(sum);
            end
         end
         MODE_H: begin
            for (int c = 0; c < 3; c++) begin
               sum = $signed({4'd0, job.base[c][ix[1]]});
               sum = ix[0] ? sum - $signed({5'd0, job.tdist})
                           : sum + $signed({5'd0, job.tdist});
               col[c] = sat8(sum);
            end
         end
         default: begin
            for (int c = 0; c < 3; c++) begin
               dx = $signed({4'd0, job.ph[c]}) - $signed({4'd0, job.po[c]});
               dy = $signed({4'd0, job.pv[c]}) - $signed({4'd0, job.po[c]});
               sum = $signed({10'd0, x}) * dx + $signed({10'd0, y}) * dy
                     + $signed({2'd0, job.po[c], 2'b10});
               col[c] = sat8(sum >>> 2);
            end
         end
      endcase
      if (job.transp && ix == 2'd2 && job.mode != MODE_PLANAR) begin
         col = '0;
         alpha = 8'd0;
      end
      k_in  = adv ? k_ff + 1'b1 : k_ff;
      ov_in = adv ? 1'b1 : (rsp.ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         ov_ff <= 1'b0;
      end else begin
         k_ff  <= k_in;
         ov_ff <= ov_in;
      end
      if (adv) begin
         ox_ff <= x;
         oy_ff <= y;
         or_ff <= col[0];
         og_ff <= col[1];
         ob_ff <= col[2];
         oa_ff <= alpha;
         ol_ff <= (k_ff == 4'd15);
      end
   end

   assign rsp.valid   = ov_ff;
   assign rsp.texel_x = ox_ff;
   assign rsp.texel_y = oy_ff;
   assign rsp.red     = or_ff;
   assign rsp.green   = og_ff;
   assign rsp.blue    = ob_ff;
   assign rsp.alpha   = oa_ff;
   assign rsp.last    = ol_ff;
endmodule

// File: sv/etc2_rgb_block_decoder.sv
// etc2 rgb8 block decoder with optional punch-through one-bit alpha
// req: one 64-bit compressed block per item, byte 0 in bits 63..56
// rsp: sixteen texel items per block, row-major (y outer, x inner), rgba8,
//   last set on the sixteenth texel
// csr: one-bit punch_through write; always ready, write only while idle
// the front classifies a block in the accept cycle (mode, base colors,
//   modifiers) and pushes it into a two-entry job queue
// the back walks sixteen texels of the head job, one per cycle while rsp
//   is not stalled, into a registered output stage
// with the back idle, an accepted block is first written into the queue,
//   then its first texel is registered into the output stage for rsp
// the output channel carries one texel per cycle while rsp is not stalled;
//   the queue lets the next block be accepted while the current one is
//   still being emitted
// reset clears the queue, the texel counter, the output valid and the
//   punch_through bit
// a stalled rsp holds its item; the back stops and the queue fills, then
//   req.ready drops
module etc2_rgb_block_decoder #(
   parameter int QueueDepth = etc2_pkg::QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   etc2_block_if.sink   req,
   etc2_texel_if.source rsp,
   etc2_csr_if.sink     csr
);
   import etc2_pkg::*;

   logic    pt_ff;
   job_type front_job, head_job;
   logic    q_full, q_empty, q_pop;

   // config register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) pt_ff <= 1'b0;
      else if (csr.valid) pt_ff <= csr.data;
   end

   etc2_front u_front (
      .punch_through (pt_ff),
      .block         (req.block),
      .job           (front_job)
   );

   assign req.ready = !q_full;

   etc2_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req.valid && !q_full),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_job),
      .empty     (q_empty)
   );

   etc2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp       (rsp)
   );
endmodule
